// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files of the pool allocator
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/scpa_pkg.sv =====
// types, codes and constants of the size-class pool allocator
// no dependencies; used by the interfaces and every module
package scpa_pkg;

   localparam int NUM_CLASSES     = 4;
   localparam int CLS_W           = 2;
   localparam int STACK_PER_CLASS = 8192;
   localparam int STACK_AW        = 13;
   localparam int DEPTH_W         = 14;
   localparam int MEM_AW          = CLS_W + STACK_AW;
   localparam int ADDR_W          = 32;
   localparam int SIZE_W          = 16;
   localparam int MODE_W          = 2;
   localparam int STATUS_W        = 2;
   localparam int USED_W          = 33;
   localparam int CSIZE_W         = 6;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = 1;
   localparam int QCNT_W          = 2;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNPOOLED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOMEM    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   // pooled sizes
   localparam logic [SIZE_W-1:0] SIZE_CLASS0 = 16'd8;
   localparam logic [SIZE_W-1:0] SIZE_CLASS1 = 16'd16;
   localparam logic [SIZE_W-1:0] SIZE_CLASS2 = 16'd24;
   localparam logic [SIZE_W-1:0] SIZE_CLASS3 = 16'd32;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE = 1'd1;

   // command kinds decided by the front end
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOP      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNPOOLED = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CLS_W-1:0]  cls;
      logic [ADDR_W-1:0] address;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // slot size in bytes of a class: (cls + 1) * 8
   function automatic logic [CSIZE_W-1:0] class_bytes(input logic [CLS_W-1:0] cls);
      return {1'b0, cls, 3'b000} + CSIZE_W'(8);
   endfunction

endpackage

// ===== rtl/core/scpa_ifs.sv =====
// request and response channel interfaces of the pool allocator
// depends on scpa_pkg for field widths
interface scpa_req_if import scpa_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [SIZE_W-1:0] size_bytes;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output mode, output size_bytes, output address,
                   input ready);
   modport sink   (input valid, input mode, input size_bytes, input address,
                   output ready);
endinterface

interface scpa_rsp_if import scpa_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   result_address;
   logic [STATUS_W-1:0] status;
   logic [CLS_W-1:0]    size_class;

   modport source (output valid, output result_address, output status, output size_class,
                   input ready);
   modport sink   (input valid, input result_address, input status, input size_class,
                   output ready);
endinterface

// ===== rtl/core/scpa_front.sv =====
// front end: accepts requests, classifies them and queues commands
// depends on scpa_pkg, scpa_ifs and assert_macros.svh
`include "assert_macros.svh"

module scpa_front import scpa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   scpa_req_if.sink       req,
   output head_type       head,
   input  logic           cmd_pop
);

   logic [CLS_W-1:0]  cls_w;
   logic              pooled;
   cmd_type           entry;
   logic              push;
   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // size to class
   always_comb begin
      cls_w  = '0;
      pooled = 1'b1;
      unique case (req.size_bytes)
         SIZE_CLASS0: cls_w = 2'd0;
         SIZE_CLASS1: cls_w = 2'd1;
         SIZE_CLASS2: cls_w = 2'd2;
         SIZE_CLASS3: cls_w = 2'd3;
         default:     pooled = 1'b0;
      endcase
   end

   always_comb begin
      entry.cls     = cls_w;
      entry.address = req.address;
      unique case (req.mode)
         MODE_ALLOC:   entry.kind = pooled ? KIND_ALLOC : KIND_UNPOOLED;
         MODE_FREE:    entry.kind = pooled ? KIND_FREE : KIND_UNPOOLED;
         MODE_RELEASE: entry.kind = KIND_RELEASE;
         MODE_NONE:    entry.kind = KIND_NOP;
      endcase
   end

   assign req.ready = !reset && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;

   assign wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = cmd_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, cmd_pop, count_ff != '0, "pop from empty command queue")

endmodule

// ===== rtl/core/scpa_back.sv =====
// back end: pool state, freed-slot stack memory and response register
// depends on scpa_pkg, scpa_ifs and assert_macros.svh
`include "assert_macros.svh"

module scpa_back import scpa_pkg::*; #(
   parameter int SLOTS_PER_BLOCK = 2048,
   parameter int MAX_BLOCKS      = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  head_type          head,
   output logic              cmd_pop,
   input  logic [ADDR_W-1:0] region_base,
   input  logic [ADDR_W-1:0] region_size,
   scpa_rsp_if.source        rsp
);

   localparam int UNC_W  = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int BLK_W  = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W = UNC_W + CSIZE_W;
   localparam logic [UNC_W-1:0] SLOTS_V     = UNC_W'(SLOTS_PER_BLOCK);
   localparam logic [UNC_W-1:0] SLOTS_LAST  = UNC_W'(SLOTS_PER_BLOCK - 1);
   localparam logic [BLK_W-1:0] MAX_BLK_V   = BLK_W'(MAX_BLOCKS);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_PER_CLASS);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic st_ff, st_in;

   logic [DEPTH_W-1:0] depth_ff    [NUM_CLASSES];
   logic [DEPTH_W-1:0] depth_in    [NUM_CLASSES];
   logic [UNC_W-1:0]   uncarved_ff [NUM_CLASSES];
   logic [UNC_W-1:0]   uncarved_in [NUM_CLASSES];
   logic [ADDR_W-1:0]  base_ff     [NUM_CLASSES];
   logic [ADDR_W-1:0]  base_in     [NUM_CLASSES];
   logic [BLK_W-1:0]   blocks_ff   [NUM_CLASSES];
   logic [BLK_W-1:0]   blocks_in   [NUM_CLASSES];
   logic [USED_W-1:0]  used_ff, used_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CLS_W-1:0]    rsp_cls_ff, rsp_cls_in;

   logic [ADDR_W-1:0] stack_mem_ff [NUM_CLASSES * STACK_PER_CLASS];
   logic [ADDR_W-1:0] rd_data_ff;
   logic              mem_re, mem_we;
   logic [MEM_AW-1:0] mem_raddr, mem_waddr;

   logic [CLS_W-1:0]   c;
   logic [DEPTH_W-1:0] cur_depth;
   logic [DEPTH_W-1:0] depth_dec;
   logic               stack_full;
   logic               out_free;
   logic               fire;
   logic [CSIZE_W-1:0] csize;
   logic [PROD_W-1:0]  blk_prod;
   logic [USED_W-1:0]  blk_bytes;
   logic               fits;
   logic               blocks_ok;
   logic               need_block;
   logic [ADDR_W-1:0]  new_base;
   logic [ADDR_W-1:0]  base_sel;
   logic [UNC_W-1:0]   u_next;
   logic [PROD_W-1:0]  offset;
   logic [ADDR_W-1:0]  slot;

   assign c          = head.cmd.cls;
   assign cur_depth  = depth_ff[c];
   assign depth_dec  = cur_depth - DEPTH_W'(1);
   assign stack_full = (cur_depth >= DEPTH_MAX);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign fire       = (st_ff == S_EXEC) && out_free;
   assign cmd_pop    = fire;

   // freed-slot stack: read the top in S_IDLE, push in S_EXEC
   assign mem_re    = (st_ff == S_IDLE) && head.valid;
   assign mem_raddr = {c, depth_dec[STACK_AW-1:0]};
   assign mem_waddr = {c, cur_depth[STACK_AW-1:0]};
   assign mem_we    = fire && (head.cmd.kind == KIND_FREE) && !stack_full;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem_ff[mem_waddr] <= head.cmd.address;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem_ff[mem_raddr];
      end
   end

   // block carving
   assign csize      = class_bytes(c);
   assign blk_prod   = PROD_W'(csize) * PROD_W'(SLOTS_V);
   assign blk_bytes  = USED_W'(blk_prod);
   assign fits       = ({1'b0, used_ff} + {1'b0, blk_bytes}) <= {2'b00, region_size};
   assign blocks_ok  = (blocks_ff[c] < MAX_BLK_V);
   assign need_block = (uncarved_ff[c] == '0);
   assign new_base   = region_base + used_ff[ADDR_W-1:0];
   assign base_sel   = need_block ? new_base : base_ff[c];
   assign u_next     = need_block ? SLOTS_LAST : uncarved_ff[c] - UNC_W'(1);
   assign offset     = PROD_W'(u_next) * PROD_W'(csize);
   assign slot       = base_sel + ADDR_W'(offset);

   always_comb begin
      st_in         = st_ff;
      depth_in      = depth_ff;
      uncarved_in   = uncarved_ff;
      base_in       = base_ff;
      blocks_in     = blocks_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cls_in    = rsp_cls_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (head.valid) begin
               st_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               st_in         = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_OK;
               rsp_cls_in    = c;
               unique case (head.cmd.kind)
                  KIND_RELEASE: begin
                     for (int i = 0; i < NUM_CLASSES; i++) begin
                        depth_in[i]    = '0;
                        uncarved_in[i] = '0;
                        base_in[i]     = '0;
                        blocks_in[i]   = '0;
                     end
                     used_in    = '0;
                     rsp_cls_in = '0;
                  end
                  KIND_UNPOOLED: begin
                     rsp_status_in = STATUS_UNPOOLED;
                     rsp_cls_in    = '0;
                  end
                  KIND_FREE: begin
                     if (stack_full) begin
                        rsp_status_in = STATUS_OVERFLOW;
                     end else begin
                        depth_in[c] = cur_depth + DEPTH_W'(1);
                     end
                  end
                  KIND_ALLOC: begin
                     if (cur_depth != '0) begin
                        depth_in[c] = depth_dec;
                        rsp_addr_in = rd_data_ff;
                     end else if (need_block && !(blocks_ok && fits)) begin
                        rsp_status_in = STATUS_NOMEM;
                     end else begin
                        if (need_block) begin
                           base_in[c]   = new_base;
                           used_in      = used_ff + blk_bytes;
                           blocks_in[c] = blocks_ff[c] + BLK_W'(1);
                        end
                        uncarved_in[c] = u_next;
                        rsp_addr_in    = slot;
                     end
                  end
                  default: begin
                     rsp_cls_in = '0;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            depth_ff[i]    <= '0;
            uncarved_ff[i] <= '0;
            base_ff[i]     <= '0;
            blocks_ff[i]   <= '0;
         end
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         depth_ff     <= depth_in;
         uncarved_ff  <= uncarved_in;
         base_ff      <= base_in;
         blocks_ff    <= blocks_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cls_ff    <= rsp_cls_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_address = rsp_addr_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.size_class     = rsp_cls_ff;

   `ASSERT_IMPLIES(a_err_zero_addr, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_addr_ff == '0, "failed transaction carries an address")
   `ASSERT_IMPLIES(a_unpooled_cls, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_UNPOOLED), rsp_cls_ff == '0, "unpooled transaction reports a class")
   `ASSERT_NEXT(a_read_then_exec, clock, reset, mem_re, st_ff == S_EXEC, "stack read not followed by execute")
   `ASSERT_NEXT(a_pop_loads_rsp, clock, reset, cmd_pop, rsp_valid_ff && (st_ff == S_IDLE), "retired command left no response")

endmodule

// ===== rtl/core/size_class_pool_allocator_unit.sv =====
// top level of the size-class pool allocator: config registers, front and back ends
// depends on scpa_pkg, scpa_ifs, scpa_front and scpa_back
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    mode, size_bytes, address
//   rsp_ch    out   valid / ready    result_address, status, size_class
//   csr_*     in    csr_we           csr_index, csr_wdata (no read-back)
//
// in the back end each transaction first reads the freed-slot stack top
// in S_IDLE, then updates the pool state and loads the response in S_EXEC
// a two-entry command queue lets the front accept while the back is busy
// a full response register stalls the back end; a full queue stalls req_ch
// synchronous active-high reset; the stack memory has no clearing pass,
// so req_ch is ready as soon as reset drops
module size_class_pool_allocator_unit import scpa_pkg::*; #(
   parameter int SLOTS_PER_BLOCK = 2048,
   parameter int MAX_BLOCKS      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   scpa_req_if.sink              req_ch,
   scpa_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // region the pool blocks are carved from
   logic [ADDR_W-1:0] region_base_ff, region_base_in;
   logic [ADDR_W-1:0] region_size_ff, region_size_in;

   head_type head;
   logic     cmd_pop;

   // config writes must only land while idle (not enforced here); no interlock with the back end
   always_comb begin
      region_base_in = region_base_ff;
      region_size_in = region_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_REGION_BASE: region_base_in = csr_wdata;
            CSR_REGION_SIZE: region_size_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         region_size_ff <= ADDR_W'(1048576);
      end else begin
         region_base_ff <= region_base_in;
         region_size_ff <= region_size_in;
      end
   end

   // classify and queue
   scpa_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .head    (head),
      .cmd_pop (cmd_pop)
   );

   // execute against pool state and stack memory
   scpa_back #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .cmd_pop     (cmd_pop),
      .region_base (region_base_ff),
      .region_size (region_size_ff),
      .rsp         (rsp_ch)
   );

endmodule
